/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Both expect a signal named clk in the scope of use; CHK_ASSERT also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/spa_pkg.sv */
// Shared constants and types of the sparse polynomial adder.
// No dependencies.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int TERMS_PER_POLY = 32;
  localparam int IDX_W  = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
  localparam int CNT_W  = $clog2(TERMS_PER_POLY + 1);
  localparam int COEF_W = 32;
  localparam int EXP_W  = 16;

  // One stored term.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic        [EXP_W-1:0]  exp;
  } term_t;

  // One result item.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic        [EXP_W-1:0]  exp;
    logic                     last;
    logic                     empty;
    logic                     overflow;
  } result_t;

endpackage

/* rtl/spa_if.sv */
// Valid/ready channel interfaces for terms in and result items out.
// Depends on spa_pkg.
`timescale 1ns / 1ps

interface spa_term_if import spa_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     second_poly;
  logic signed [COEF_W-1:0] coefficient;
  logic        [EXP_W-1:0]  exponent;
  logic                     last_term;

  modport source (output valid, second_poly, coefficient, exponent, last_term,
                  input ready);
  modport sink   (input valid, second_poly, coefficient, exponent, last_term,
                  output ready);
endinterface

interface spa_result_if import spa_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] sum_coefficient;
  logic        [EXP_W-1:0]  sum_exponent;
  logic                     last_result;
  logic                     empty_result;
  logic                     overflow_seen;

  modport source (output valid, sum_coefficient, sum_exponent, last_result,
                  empty_result, overflow_seen, input ready);
  modport sink   (input valid, sum_coefficient, sum_exponent, last_result,
                  empty_result, overflow_seen, output ready);
endinterface

/* rtl/spa_term_ram.sv */
// Simple dual-port term store: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module spa_term_ram #(
  parameter int  DEPTH = 32,
  parameter int  WIDTH = 48,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sparse_polynomial_adder_unit.sv */
// Sparse polynomial adder top level: term loading, merge sequencer, output register.
// Depends on spa_pkg, spa_if and spa_term_ram.
`timescale 1ns / 1ps

// term carries terms of two polynomials, each in descending exponent order;
// second_poly picks the polynomial. A taken term is stored in
// that polynomial's term memory; terms past TERMS_PER_POLY are dropped and
// reported through overflow_seen on every item of the next result.
// The second polynomial's term with last_term set starts the merge. term
// stays not ready until the merge has handed its final item to the output
// register. Each merge step first reads the term memories, whose read port
// is registered, then compares and adds the two heads of the polynomials.
// A result item is held back one step so the final item can carry
// last_result; if every term cancels a single item with empty_result set and
// a zero term is sent. result holds an item until ready is seen; a stalled
// receiver freezes the merge. Reset (rst, synchronous) empties both
// polynomials and drops any pending result.
module sparse_polynomial_adder_unit import spa_pkg::*; (
  input logic         clk,
  input logic         rst,
  spa_term_if.sink    term,
  spa_result_if.source result
);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_READ  = 4'b0010,
    S_CMP   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] first_count;
  logic [CNT_W-1:0] second_count;
  logic             dropped;
  logic [CNT_W-1:0] idx_a;
  logic [CNT_W-1:0] idx_b;
  result_t          pend;
  logic             pend_valid;
  result_t          out_reg;
  logic             out_valid;

  logic    in_take, a_room, b_room, we_a, we_b;
  logic    has_a, has_b, out_free, cmp_go;
  logic    cand_valid, adv_a, adv_b, out_load;
  result_t cand;
  term_t   wr_term, rd_a, rd_b;
  logic signed [COEF_W:0]   wide_sum;
  logic signed [COEF_W-1:0] sat_sum;

  assign term.ready = (state == S_LOAD);

  always_comb begin
    in_take  = term.valid && term.ready;
    a_room   = first_count < CNT_W'(TERMS_PER_POLY);
    b_room   = second_count < CNT_W'(TERMS_PER_POLY);
    we_a     = in_take && !term.second_poly && a_room;
    we_b     = in_take && term.second_poly && b_room;
    wr_term  = '{coef: term.coefficient, exp: term.exponent};
    has_a    = idx_a < first_count;
    has_b    = idx_b < second_count;
    out_free = !out_valid || result.ready;
  end

  spa_term_ram #(.DEPTH(TERMS_PER_POLY), .WIDTH($bits(term_t))) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (first_count[IDX_W-1:0]),
    .wdata (wr_term),
    .raddr (idx_a[IDX_W-1:0]),
    .rdata (rd_a)
  );

  spa_term_ram #(.DEPTH(TERMS_PER_POLY), .WIDTH($bits(term_t))) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (second_count[IDX_W-1:0]),
    .wdata (wr_term),
    .raddr (idx_b[IDX_W-1:0]),
    .rdata (rd_b)
  );

  // Saturating add of equal-exponent coefficients.
  always_comb begin
    wide_sum = {rd_a.coef[COEF_W-1], rd_a.coef} + {rd_b.coef[COEF_W-1], rd_b.coef};
    if (wide_sum[COEF_W] != wide_sum[COEF_W-1]) begin
      sat_sum = wide_sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sat_sum = wide_sum[COEF_W-1:0];
    end
  end

  // Pick the next result candidate from the two heads.
  always_comb begin
    cand       = '{coef: rd_b.coef, exp: rd_b.exp, last: 1'b0, empty: 1'b0,
                   overflow: dropped};
    cand_valid = 1'b1;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    if (has_a && has_b) begin
      if (rd_a.exp > rd_b.exp) begin
        cand.coef = rd_a.coef;
        cand.exp  = rd_a.exp;
        adv_a     = 1'b1;
      end else if (rd_a.exp < rd_b.exp) begin
        adv_b = 1'b1;
      end else begin
        cand.coef  = sat_sum;
        cand_valid = (sat_sum != '0);
        adv_a      = 1'b1;
        adv_b      = 1'b1;
      end
    end else if (has_a) begin
      cand.coef = rd_a.coef;
      cand.exp  = rd_a.exp;
      adv_a     = 1'b1;
    end else begin
      adv_b = 1'b1;
    end
    // a new candidate displaces the pending item only if the output can take it
    cmp_go = !(cand_valid && pend_valid && !out_free);
    // output register loads a displaced pending item or the final item
    out_load = (state == S_CMP && cmp_go && cand_valid && pend_valid) ||
               (state == S_FLUSH && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
      idx_a        <= '0;
      idx_b        <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_take) begin
            if (!term.second_poly) begin
              if (a_room) begin
                first_count <= first_count + CNT_W'(1);
              end else begin
                dropped <= 1'b1;
              end
            end else begin
              if (b_room) begin
                second_count <= second_count + CNT_W'(1);
              end else begin
                dropped <= 1'b1;
              end
              if (term.last_term) begin
                idx_a <= '0;
                idx_b <= '0;
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= (has_a || has_b) ? S_CMP : S_FLUSH;
        end
        S_CMP: begin
          if (cmp_go) begin
            if (adv_a) begin
              idx_a <= idx_a + CNT_W'(1);
            end
            if (adv_b) begin
              idx_b <= idx_b + CNT_W'(1);
            end
            if (cand_valid) begin
              pend       <= cand;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                out_reg   <= pend;
                out_valid <= 1'b1;
              end
            end
            state <= S_READ;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            if (pend_valid) begin
              out_reg <= '{coef: pend.coef, exp: pend.exp, last: 1'b1, empty: pend.empty,
                           overflow: pend.overflow};
            end else begin
              out_reg <= '{coef: '0, exp: '0, last: 1'b1, empty: 1'b1,
                           overflow: dropped};
            end
            out_valid    <= 1'b1;
            pend_valid   <= 1'b0;
            first_count  <= '0;
            second_count <= '0;
            dropped      <= 1'b0;
            state        <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign result.valid           = out_valid;
  assign result.sum_coefficient = out_reg.coef;
  assign result.sum_exponent    = out_reg.exp;
  assign result.last_result     = out_reg.last;
  assign result.empty_result    = out_reg.empty;
  assign result.overflow_seen   = out_reg.overflow;

endmodule

/* rtl/spa_checker.sv */
// Port-level checks for the sparse polynomial adder, bound to the top level.
// Depends on spa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spa_checker import spa_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     term_valid,
  input logic                     term_ready,
  input logic                     term_second,
  input logic                     term_last,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic signed [COEF_W-1:0] res_coef,
  input logic        [EXP_W-1:0]  res_exp,
  input logic                     res_last,
  input logic                     res_empty,
  input logic                     res_overflow
);

  `CHK_ASSERT_ALWAYS(a_reset_idle, rst |=> !res_valid, "result valid after reset")

  `CHK_ASSERT(a_stall_hold, res_valid && !res_ready |=> res_valid && $stable(res_coef) && $stable(res_exp) && $stable(res_last) && $stable(res_empty) && $stable(res_overflow), "stalled result changed")

  `CHK_ASSERT(a_empty_is_last, res_valid && res_empty |-> res_last, "empty marker without last mark")

  `CHK_ASSERT(a_empty_zero, res_valid && res_empty |-> res_coef == '0 && res_exp == '0, "empty marker carries a term")

  `CHK_ASSERT(a_merge_blocks, term_valid && term_ready && term_second && term_last |=> !term_ready, "terms taken while merging")

endmodule

bind sparse_polynomial_adder_unit spa_checker u_spa_checker (
  .clk          (clk),
  .rst          (rst),
  .term_valid   (term.valid),
  .term_ready   (term.ready),
  .term_second  (term.second_poly),
  .term_last    (term.last_term),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_coef     (result.sum_coefficient),
  .res_exp      (result.sum_exponent),
  .res_last     (result.last_result),
  .res_empty    (result.empty_result),
  .res_overflow (result.overflow_seen)
);

/* tb/sv/sparse_polynomial_adder_unit_tb.sv */
// Testbench for sparse_polynomial_adder_unit: loads pairs of sparse polynomials, predicts
// the merged sum and checks every result item with a scoreboard class.
// Depends on spa_pkg, spa_if and the RTL of the block.
`timescale 1ns / 1ps

module sparse_polynomial_adder_unit_tb;
  import spa_pkg::*;

  localparam logic FIRST_POLY  = 1'b0;
  localparam logic SECOND_POLY = 1'b1;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;
  localparam int RANDOM_TERMS = 420;

  typedef struct packed {
    logic                     second;
    logic signed [COEF_W-1:0] coef;
    logic        [EXP_W-1:0]  exp;
    logic                     last;
  } load_item_t;

  // Own copy of both term stores; a merge turns them into the result items due.
  class poly_sum_scoreboard;
    logic signed [COEF_W-1:0] first_coef [TERMS_PER_POLY];
    logic        [EXP_W-1:0]  first_exp  [TERMS_PER_POLY];
    logic signed [COEF_W-1:0] second_coef [TERMS_PER_POLY];
    logic        [EXP_W-1:0]  second_exp  [TERMS_PER_POLY];
    int first_len, second_len;
    bit lost_term;
    result_t sum_terms_due[$];
    int errors, terms_seen, merges, results_seen, empties, saturations, overflow_merges;

    function int pending();
      return sum_terms_due.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    function logic signed [COEF_W-1:0] add_clamped(logic signed [COEF_W-1:0] a,
                                                  logic signed [COEF_W-1:0] b);
      logic signed [COEF_W-1:0] s;
      s = a + b;
      if (a[COEF_W-1] == b[COEF_W-1] && s[COEF_W-1] != a[COEF_W-1]) begin
        saturations++;
        s = a[COEF_W-1] ? COEF_MIN : COEF_MAX;
      end
      return s;
    endfunction

    function void queue_term(logic signed [COEF_W-1:0] c, logic [EXP_W-1:0] e);
      result_t r;
      r.coef = c;
      r.exp = e;
      r.last = 1'b0;
      r.empty = 1'b0;
      r.overflow = lost_term;
      sum_terms_due.push_back(r);
    endfunction

    function void note_term(load_item_t t);
      int i, j, start;
      logic signed [COEF_W-1:0] s;
      result_t r;
      terms_seen++;
      if (t.second == FIRST_POLY) begin
        if (first_len < TERMS_PER_POLY) begin
          first_coef[first_len] = t.coef;
          first_exp[first_len] = t.exp;
          first_len++;
        end else lost_term = 1;
        return;
      end
      if (second_len < TERMS_PER_POLY) begin
        second_coef[second_len] = t.coef;
        second_exp[second_len] = t.exp;
        second_len++;
      end else lost_term = 1;
      if (!t.last) return;

      merges++;
      start = sum_terms_due.size();
      i = 0;
      j = 0;
      while (i < first_len && j < second_len) begin
        if (first_exp[i] > second_exp[j]) begin
          queue_term(first_coef[i], first_exp[i]);
          i++;
        end else if (first_exp[i] < second_exp[j]) begin
          queue_term(second_coef[j], second_exp[j]);
          j++;
        end else begin
          s = add_clamped(first_coef[i], second_coef[j]);
          if (s != 0) queue_term(s, first_exp[i]);
          i++;
          j++;
        end
      end
      for (; i < first_len; i++) queue_term(first_coef[i], first_exp[i]);
      for (; j < second_len; j++) queue_term(second_coef[j], second_exp[j]);
      // everything cancelled: a single marker item with a zero term
      if (sum_terms_due.size() == start) begin
        queue_term('0, '0);
        r = sum_terms_due.pop_back();
        r.empty = 1'b1;
        sum_terms_due.push_back(r);
        empties++;
      end
      r = sum_terms_due.pop_back();
      r.last = 1'b1;
      sum_terms_due.push_back(r);
      if (lost_term) overflow_merges++;
      first_len = 0;
      second_len = 0;
      lost_term = 0;
    endfunction

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (sum_terms_due.size() == 0) begin
        report_mismatch($sformatf("result item with nothing due: coef %h exp %0d",
                                  got.coef, got.exp));
        return;
      end
      want = sum_terms_due.pop_front();
      if (got.coef !== want.coef || got.exp !== want.exp || got.last !== want.last ||
          got.empty !== want.empty || got.overflow !== want.overflow)
        report_mismatch($sformatf(
          "item %0d: got coef %h exp %0d last %b empty %b ovf %b, want %h %0d %b %b %b",
          results_seen, got.coef, got.exp, got.last, got.empty, got.overflow,
          want.coef, want.exp, want.last, want.empty, want.overflow));
    endtask
  endclass

  logic clk;
  logic rst;
  spa_term_if   term_if ();
  spa_result_if res_if ();

  sparse_polynomial_adder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .term   (term_if),
    .result (res_if)
  );

  poly_sum_scoreboard sb = new();
  load_item_t pending_terms[$];
  int burst_left = 0;
  int random_terms = 0;
  int pair_no = 0;
  int stall_mode = 0;
  int mode_left = 0;
  logic [2:0] stall_phase = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: switches between free flow, light and heavy random stalls,
  // and a periodic stall pattern.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 120);
    end else mode_left <= mode_left - 1;
    stall_phase <= stall_phase + 1'b1;
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      2: res_if.ready <= ($urandom_range(0, 3) == 0);
      default: res_if.ready <= (stall_phase < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(result_t'{res_if.sum_coefficient, res_if.sum_exponent,
                                 res_if.last_result, res_if.empty_result,
                                 res_if.overflow_seen});
  end

  function automatic void add_term(logic s, logic signed [COEF_W-1:0] c,
                                   logic [EXP_W-1:0] e, logic l);
    pending_terms.push_back('{s, c, e, l});
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COEF_MAX;
      2: return COEF_MIN;
      3: return $urandom_range(1, 32'h0003_FFFF);
      4: return -$signed({1'b0, 31'($urandom_range(1, 32'h0003_FFFF))});
      default: return $urandom;
    endcase
  endfunction

  task automatic send_term(load_item_t t);
    @(negedge clk);
    term_if.valid <= 1'b1;
    term_if.second_poly <= t.second;
    term_if.coefficient <= t.coef;
    term_if.exponent <= t.exp;
    term_if.last_term <= t.last;
    do @(posedge clk); while (term_if.ready !== 1'b1);
    sb.note_term(t);
  endtask

  task automatic pause_terms(int n);
    if (n > 0) begin
      @(negedge clk);
      term_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drive_terms();
    load_item_t t;
    while (pending_terms.size() != 0) begin
      t = pending_terms.pop_front();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 10);
        pause_terms($urandom_range(0, 8));
      end
      burst_left--;
      send_term(t);
    end
  endtask

  // Sender holds off until every result item due has been taken.
  task automatic wait_drained();
    @(negedge clk);
    term_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One pair of polynomials over a shared descending exponent list; each exponent
  // goes to the first, the second or both. Broken pairs scramble exponents and marks.
  task automatic build_pair(bit force_big);
    load_item_t fq[$], sq[$], t;
    logic [EXP_W-1:0] exps[$];
    logic signed [COEF_W-1:0] c, pc;
    int m, cur, step, role, n;
    bit big, broken;
    big = force_big || ($urandom_range(0, 15) == 0);
    broken = !big && ($urandom_range(0, 9) == 0);
    m = big ? $urandom_range(36, 50) : $urandom_range(1, 8);
    cur = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(m - 1, 65535);
    for (int k = 0; k < m; k++) begin
      if (k == m - 1 && $urandom_range(0, 3) == 0) cur = 0;
      exps.push_back(EXP_W'(cur));
      if (k < m - 1) begin
        step = $urandom_range(1, 3000);
        if (cur - step < m - 2 - k) step = cur - (m - 2 - k);
        cur -= step;
      end
    end
    foreach (exps[k]) begin
      if (big) role = ($urandom_range(0, 7) < 2) ? $urandom_range(0, 1) : 2;
      else role = $urandom_range(0, 3);
      c = pick_coef();
      case ($urandom_range(0, 3))
        0: pc = -c;
        1: pc = c;
        default: pc = pick_coef();
      endcase
      if (role != 1) fq.push_back('{FIRST_POLY, c, exps[k], $urandom_range(0, 7) == 0});
      if (role == 1) sq.push_back('{SECOND_POLY, c, exps[k], 1'b0});
      else if (role >= 2) sq.push_back('{SECOND_POLY, pc, exps[k], 1'b0});
    end
    if (sq.size() == 0) sq.push_back('{SECOND_POLY, pick_coef(), exps[m - 1], 1'b0});
    if (broken) begin
      foreach (fq[k]) fq[k].exp = EXP_W'($urandom_range(0, 65535));
      foreach (sq[k]) begin
        sq[k].exp = EXP_W'($urandom_range(0, 65535));
        sq[k].last = ($urandom_range(0, 3) == 0);
      end
    end else if (fq.size() != 0 && $urandom_range(0, 1) == 1) begin
      t = fq.pop_back();
      t.last = 1'b1;
      fq.push_back(t);
    end
    t = sq.pop_back();
    t.last = 1'b1;
    sq.push_back(t);
    // interleave the two polynomials, keeping the merge-starting term last
    n = fq.size() + sq.size();
    while (fq.size() + sq.size() != 0) begin
      if (sq.size() == 0 || (fq.size() != 0 && (sq.size() == 1 || $urandom_range(0, 1) == 1)))
        pending_terms.push_back(fq.pop_front());
      else pending_terms.push_back(sq.pop_front());
    end
    random_terms += n;
  endtask

  initial begin
    rst = 1'b1;
    term_if.valid = 1'b0;
    term_if.second_poly = FIRST_POLY;
    term_if.coefficient = '0;
    term_if.exponent = '0;
    term_if.last_term = 1'b0;
    res_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extreme exponents, last mark on first polynomial ignored, zero coefficient
    // copied, positive saturation, a cancelling pair at the tail
    add_term(FIRST_POLY, 32'sh0001_0000, 16'd65535, 1'b1);
    add_term(FIRST_POLY, '0, 16'd300, 1'b0);
    add_term(FIRST_POLY, 32'sh0002_8000, 16'd0, 1'b1);
    add_term(SECOND_POLY, COEF_MAX, 16'd65535, 1'b0);
    add_term(SECOND_POLY, 32'shFFFF_0000, 16'd1000, 1'b0);
    add_term(SECOND_POLY, -32'sh0002_8000, 16'd0, 1'b1);
    // every term cancels
    add_term(FIRST_POLY, 32'sd7, 16'd4, 1'b0);
    add_term(FIRST_POLY, -32'sd5, 16'd2, 1'b0);
    add_term(SECOND_POLY, -32'sd7, 16'd4, 1'b0);
    add_term(SECOND_POLY, 32'sd5, 16'd2, 1'b1);
    // negative saturation, first polynomial out of order
    add_term(FIRST_POLY, COEF_MIN, 16'd9, 1'b0);
    add_term(FIRST_POLY, 32'sd5, 16'd20, 1'b0);
    add_term(SECOND_POLY, -32'sd1, 16'd9, 1'b0);
    add_term(SECOND_POLY, 32'shDEAD_BEEF, 16'd7, 1'b1);
    // interleaved loads, zero sum dropped, zero term copied
    add_term(SECOND_POLY, 32'sh4000_0000, 16'd12, 1'b0);
    add_term(FIRST_POLY, 32'shC000_0000, 16'd12, 1'b0);
    add_term(SECOND_POLY, '0, 16'd0, 1'b1);
    // sum lands exactly on the positive limit
    add_term(FIRST_POLY, 32'sh7FFF_FFFE, 16'd1, 1'b0);
    add_term(SECOND_POLY, 32'sd1, 16'd1, 1'b1);
    drive_terms();
    wait_drained();

    while (random_terms < RANDOM_TERMS) begin
      build_pair(pair_no == 3);
      drive_terms();
      pair_no++;
      if (pair_no % 6 == 0) wait_drained();
    end
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d result items never arrived", sb.pending()));

    $display("Covered %0d terms in %0d merges, %0d result items checked.",
             sb.terms_seen, sb.merges, sb.results_seen);
    $display("%0d all-cancelled results, %0d saturated sums, %0d merges with dropped terms.",
             sb.empties, sb.saturations, sb.overflow_merges);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("TIMEOUT: run did not finish, %0d result items still due", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/spa_pkg.sv
rtl/spa_if.sv
rtl/spa_term_ram.sv
rtl/sparse_polynomial_adder_unit.sv
rtl/spa_checker.sv
tb/sv/sparse_polynomial_adder_unit_tb.sv
